// File: sv/timer_deadline_queue_defines.svh
// Assertion helpers for the timer queue checker
`ifndef TIMER_DEADLINE_QUEUE_DEFINES_SVH
`define TIMER_DEADLINE_QUEUE_DEFINES_SVH

// same-cycle implication on clk, quiet while arst_n is low
`define TDQ_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("timer queue check failed");

// next-cycle implication on clk, quiet while arst_n is low
`define TDQ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("timer queue check failed");

`endif

// File: sv/tdq_pkg.sv
package tdq_pkg;

	localparam int MODE_W   = 2;
	localparam int STATUS_W = 2;
	localparam int OFFSET_W = 32;

	localparam logic [MODE_W-1:0] MODE_SET    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_POLL   = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic                load;
		logic                add;
		logic                store;
		logic                scan_init;
		logic                cmp_init;
		logic                walk;
		logic                eval;
		logic                move;
		logic                retire;
		logic                post;
		logic [STATUS_W-1:0] st;
	} cmd_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              full;
		logic              empty;
		logic              walk_done;
		logic              found;
	} stat_t;

endpackage

// File: sv/tdq_ctrl.sv
module tdq_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  tdq_pkg::stat_t stat,
	output tdq_pkg::cmd_t  cmd,
	output logic           busy
);

	typedef enum logic [5:0] {
		S_IDLE    = 6'b000001,
		S_DECODE  = 6'b000010,
		S_STORE   = 6'b000100,
		S_SCAN    = 6'b001000,
		S_PICK    = 6'b010000,
		S_COMPACT = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.st  = tdq_pkg::ST_MISS;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (stat.mode) inside
					tdq_pkg::MODE_SET: begin
						if (stat.full) begin
							cmd.post = 1'b1;
							cmd.st   = tdq_pkg::ST_FULL;
							state_d  = S_IDLE;
						end else begin
							cmd.add = 1'b1;
							state_d = S_STORE;
						end
					end
					tdq_pkg::MODE_DELETE, tdq_pkg::MODE_POLL: begin
						if (stat.empty) begin
							cmd.post = 1'b1;
							state_d  = S_IDLE;
						end else begin
							cmd.scan_init = 1'b1;
							state_d       = S_SCAN;
						end
					end
					default: begin
						cmd.post = 1'b1;
						state_d  = S_IDLE;
					end
				endcase
			end
			S_STORE: begin
				cmd.store = 1'b1;
				cmd.post  = 1'b1;
				cmd.st    = tdq_pkg::ST_OK;
				state_d   = S_IDLE;
			end
			S_SCAN: begin
				cmd.walk = 1'b1;
				cmd.eval = 1'b1;
				if (stat.walk_done) begin
					state_d = S_PICK;
				end
			end
			S_PICK: begin
				if (stat.found) begin
					cmd.cmp_init = 1'b1;
					state_d      = S_COMPACT;
				end else begin
					cmd.post = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_COMPACT: begin
				cmd.walk = 1'b1;
				cmd.move = 1'b1;
				if (stat.walk_done) begin
					cmd.retire = 1'b1;
					cmd.post   = 1'b1;
					cmd.st     = tdq_pkg::ST_OK;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

endmodule

// File: sv/tdq_datapath.sv
module tdq_datapath #(
	parameter int MAX_TIMERS = 64,
	parameter int TIME_BITS  = 48,
	parameter int ID_BITS    = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [tdq_pkg::MODE_W-1:0]           mode,
	input  logic [TIME_BITS-1:0]                 now_ms,
	input  logic [TIME_BITS-1:0]                 delay_ms,
	input  logic signed [tdq_pkg::OFFSET_W-1:0]  offset_ms,
	input  logic [ID_BITS-1:0]                   timer_id,
	input  tdq_pkg::cmd_t                        cmd,
	output tdq_pkg::stat_t                       stat,
	output logic                                 done,
	output logic [tdq_pkg::STATUS_W-1:0]         status,
	output logic [ID_BITS-1:0]                   result_id,
	output logic [$clog2(MAX_TIMERS+1)-1:0]      live_count
);

	localparam int AW = $clog2(MAX_TIMERS);
	localparam int CW = $clog2(MAX_TIMERS + 1);
	localparam int SW = TIME_BITS + 1;
	localparam int OW = tdq_pkg::OFFSET_W;
	localparam int DW = (TIME_BITS + 3 > OW + 2) ? TIME_BITS + 3 : OW + 2;
	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_TIMERS);
	localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

	logic [TIME_BITS-1:0] dl_mem [MAX_TIMERS];
	logic [ID_BITS-1:0]   id_mem [MAX_TIMERS];

	logic [tdq_pkg::MODE_W-1:0] mode_q;
	logic [TIME_BITS-1:0]       now_q;
	logic [TIME_BITS-1:0]       delay_q;
	logic [OW-1:0]              off_q;
	logic [ID_BITS-1:0]         tid_q;
	logic [SW-1:0]              sum_q;
	logic [CW-1:0]              count_q;
	logic [ID_BITS-1:0]         ctr_q;
	logic [CW-1:0]              idx_q;
	logic [CW-1:0]              pidx_q;
	logic                       pv_q;
	logic                       found_q;
	logic [CW-1:0]              best_q;
	logic [TIME_BITS-1:0]       best_dl_q;
	logic [ID_BITS-1:0]         best_id_q;
	logic [TIME_BITS-1:0]       rdl_q;
	logic [ID_BITS-1:0]         rid_q;
	logic                       done_q;
	logic [tdq_pkg::STATUS_W-1:0] status_q;
	logic [ID_BITS-1:0]         rid_out_q;
	logic [CW-1:0]              live_q;

	logic [ID_BITS-1:0]   ctr_inc, ctr_nx;
	logic [DW-1:0]        tot;
	logic                 over;
	logic [TIME_BITS-1:0] deadline;
	logic                 walk_lt, rd_en;
	logic                 hit_poll, hit_del;
	logic                 we;
	logic [AW-1:0]        wa;
	logic [CW-1:0]        pidx_dec;
	logic [TIME_BITS-1:0] wdl;
	logic [ID_BITS-1:0]   wid;
	logic [CW-1:0]        count_nx;
	logic [ID_BITS-1:0]   rid_sel;

	always_comb begin
		ctr_inc  = ctr_q + 1'b1;
		ctr_nx   = (ctr_inc == '0) ? ID_BITS'(1) : ctr_inc;
		tot      = {{(DW - SW){1'b0}}, sum_q} + {{(DW - OW){off_q[OW-1]}}, off_q};
		over     = !tot[DW-1] && (|tot[DW-2:TIME_BITS]);
		deadline = tot[DW-1] ? '0 : (over ? TIME_MAX : tot[TIME_BITS-1:0]);
		walk_lt  = (idx_q < count_q);
		rd_en    = cmd.walk && walk_lt;
		hit_poll = cmd.eval && pv_q && (mode_q == tdq_pkg::MODE_POLL) &&
			(rdl_q <= now_q) && (!found_q || (rdl_q < best_dl_q));
		hit_del  = cmd.eval && pv_q && (mode_q == tdq_pkg::MODE_DELETE) &&
			!found_q && (rid_q == tid_q);
		pidx_dec = pidx_q - 1'b1;
		we       = cmd.store || (cmd.move && pv_q);
		wa       = cmd.store ? count_q[AW-1:0] : pidx_dec[AW-1:0];
		wdl      = cmd.store ? deadline : rdl_q;
		wid      = cmd.store ? ctr_nx : rid_q;
		if (cmd.store) begin
			count_nx = count_q + 1'b1;
		end else if (cmd.retire) begin
			count_nx = count_q - 1'b1;
		end else begin
			count_nx = count_q;
		end
		rid_sel = '0;
		if (cmd.st == tdq_pkg::ST_OK) begin
			if (mode_q == tdq_pkg::MODE_SET) begin
				rid_sel = ctr_nx;
			end else if (mode_q == tdq_pkg::MODE_POLL) begin
				rid_sel = best_id_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			dl_mem[wa] <= wdl;
			id_mem[wa] <= wid;
		end
		if (rd_en) begin
			rdl_q <= dl_mem[idx_q[AW-1:0]];
			rid_q <= id_mem[idx_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q  <= mode;
			now_q   <= now_ms;
			delay_q <= delay_ms;
			off_q   <= offset_ms;
			tid_q   <= timer_id;
		end
		if (cmd.add) begin
			sum_q <= {1'b0, now_q} + {1'b0, delay_q};
		end
		if (rd_en) begin
			pidx_q <= idx_q;
		end
		if (hit_poll || hit_del) begin
			best_q    <= pidx_q;
			best_dl_q <= rdl_q;
			best_id_q <= rid_q;
		end
		if (cmd.post) begin
			status_q  <= cmd.st;
			rid_out_q <= rid_sel;
			live_q    <= count_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ctr_q   <= '0;
			idx_q   <= '0;
			pv_q    <= 1'b0;
			found_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_nx;
			done_q  <= cmd.post;
			if (cmd.store) begin
				ctr_q <= ctr_nx;
			end
			if (cmd.scan_init) begin
				idx_q   <= '0;
				pv_q    <= 1'b0;
				found_q <= 1'b0;
			end else if (cmd.cmp_init) begin
				idx_q <= best_q + 1'b1;
				pv_q  <= 1'b0;
			end else if (cmd.walk) begin
				pv_q <= walk_lt;
				if (walk_lt) begin
					idx_q <= idx_q + 1'b1;
				end
			end
			if (hit_poll || hit_del) begin
				found_q <= 1'b1;
			end
		end
	end

	assign stat.mode      = mode_q;
	assign stat.full      = (count_q == CNT_MAX);
	assign stat.empty     = (count_q == '0);
	assign stat.walk_done = !pv_q && !walk_lt;
	assign stat.found     = found_q;

	assign done       = done_q;
	assign status     = status_q;
	assign result_id  = rid_out_q;
	assign live_count = live_q;

endmodule

// File: sv/timer_deadline_queue.sv
// Table of one-shot timers held in insertion order.
// Command channel: a word is taken when start is high and busy is low. mode
// selects set (store now_ms+delay_ms+offset_ms, saturated, under a fresh id),
// delete (remove the entry named by timer_id) or poll (remove and return the
// earliest expired entry, the oldest winning ties).
// Result channel: done is high for exactly one cycle with status, result_id
// and live_count; the receiver cannot hold it off and busy is low by then.
// Steps of a set: decode and add, saturate and write, then done. Delete and
// poll: one pass reads the table through the single memory read port to
// find the entry and, if one is found, a second pass copies each later
// entry down one slot.
// Items are handled one at a time; a new word may be taken in the cycle that
// done is high.
// Reset clears the entry count and id counter, not the live_count register;
// the table memory is not cleared: only entries below the count are read.
module timer_deadline_queue #(
	parameter int MAX_TIMERS = 64,
	parameter int TIME_BITS  = 48,
	parameter int ID_BITS    = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic [tdq_pkg::MODE_W-1:0]           mode,
	input  logic [TIME_BITS-1:0]                 now_ms,
	input  logic [TIME_BITS-1:0]                 delay_ms,
	input  logic signed [tdq_pkg::OFFSET_W-1:0]  offset_ms,
	input  logic [ID_BITS-1:0]                   timer_id,
	output logic                                 busy,
	output logic                                 done,
	output logic [tdq_pkg::STATUS_W-1:0]         status,
	output logic [ID_BITS-1:0]                   result_id,
	output logic [$clog2(MAX_TIMERS+1)-1:0]      live_count
);

	tdq_pkg::cmd_t  cmd;
	tdq_pkg::stat_t stat;

	tdq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	tdq_datapath #(
		.MAX_TIMERS (MAX_TIMERS),
		.TIME_BITS  (TIME_BITS),
		.ID_BITS    (ID_BITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.mode       (mode),
		.now_ms     (now_ms),
		.delay_ms   (delay_ms),
		.offset_ms  (offset_ms),
		.timer_id   (timer_id),
		.cmd        (cmd),
		.stat       (stat),
		.done       (done),
		.status     (status),
		.result_id  (result_id),
		.live_count (live_count)
	);

endmodule

// File: sv/tdq_checker.sv
`include "timer_deadline_queue_defines.svh"

module tdq_checker #(
	parameter int MAX_TIMERS = 64,
	parameter int ID_BITS    = 32
) (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 start,
	input logic                                 busy,
	input logic                                 done,
	input logic [tdq_pkg::STATUS_W-1:0]         status,
	input logic [ID_BITS-1:0]                   result_id,
	input logic [$clog2(MAX_TIMERS+1)-1:0]      live_count
);

	localparam logic [$clog2(MAX_TIMERS+1)-1:0] CNT_MAX = ($clog2(MAX_TIMERS+1))'(MAX_TIMERS);

	`TDQ_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
	`TDQ_ASSERT_NOW(a_done_idle, done, !busy)
	`TDQ_ASSERT_NOW(a_fell_done, $fell(busy), done)
	`TDQ_ASSERT_NOW(a_miss_zero, done && (status != tdq_pkg::ST_OK), result_id == '0)
	`TDQ_ASSERT_NOW(a_full_count, done && (status == tdq_pkg::ST_FULL), live_count == CNT_MAX)

endmodule

bind timer_deadline_queue tdq_checker #(
	.MAX_TIMERS (MAX_TIMERS),
	.ID_BITS    (ID_BITS)
) u_tdq_checker (.*);

// File: sim/timer_deadline_queue_test.sv
`timescale 1ns / 1ps

module timer_deadline_queue_test;

	localparam int MAX_T  = 64;
	localparam int TIME_W = 48;
	localparam int ID_W   = 32;
	localparam int CNT_W  = $clog2(MAX_T + 1);
	localparam int QUIET_LIMIT = 4000;

	localparam logic [tdq_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;
	localparam logic [TIME_W-1:0]   TIME_TOP   = {TIME_W{1'b1}};
	localparam logic signed [31:0]  OFF_MIN    = 32'h8000_0000;
	localparam logic signed [31:0]  OFF_MAX    = 32'h7FFF_FFFF;

	typedef struct packed {
		logic [tdq_pkg::STATUS_W-1:0] status;
		logic [ID_W-1:0]     id;
		logic [CNT_W-1:0]    count;
	} reply_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       start = 1'b0;
	logic [tdq_pkg::MODE_W-1:0] mode = tdq_pkg::MODE_POLL;
	logic [TIME_W-1:0]          now_ms = '0;
	logic [TIME_W-1:0]          delay_ms = '0;
	logic signed [tdq_pkg::OFFSET_W-1:0] offset_ms = '0;
	logic [ID_W-1:0]            timer_id = '0;
	logic                       busy;
	logic                       done;
	logic [tdq_pkg::STATUS_W-1:0] status;
	logic [ID_W-1:0]            result_id;
	logic [CNT_W-1:0]           live_count;

	// timer table as the block should hold it
	logic [TIME_W-1:0] sched_deadline [MAX_T];
	logic [ID_W-1:0]   sched_ident [MAX_T];
	int                sched_count = 0;
	logic [ID_W-1:0]   last_id = '0;

	reply_t expected_replies[$];
	int     mismatches = 0;
	int     quiet_cycles = 0;
	logic [TIME_W-1:0] clock_ms = 48'd1000;
	bit     filling = 1'b1;

	timer_deadline_queue #(
		.MAX_TIMERS(MAX_T),
		.TIME_BITS (TIME_W),
		.ID_BITS   (ID_W)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.mode      (mode),
		.now_ms    (now_ms),
		.delay_ms  (delay_ms),
		.offset_ms (offset_ms),
		.timer_id  (timer_id),
		.busy      (busy),
		.done      (done),
		.status    (status),
		.result_id (result_id),
		.live_count(live_count)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [TIME_W-1:0] rand_time();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[TIME_W-1:0];
	endfunction

	function automatic void drop_entry(input int pos);
		for (int i = pos; i + 1 < sched_count; i++) begin
			sched_deadline[i] = sched_deadline[i + 1];
			sched_ident[i]    = sched_ident[i + 1];
		end
		sched_count--;
	endfunction

	function automatic reply_t apply_timer_op(input logic [tdq_pkg::MODE_W-1:0] op,
		input logic [TIME_W-1:0] now, input logic [TIME_W-1:0] delay,
		input logic signed [31:0] off, input logic [ID_W-1:0] tid);
		reply_t r;
		longint sum;
		int hit;
		r.status = tdq_pkg::ST_MISS;
		r.id = '0;
		hit = -1;
		case (op)
			tdq_pkg::MODE_SET: begin
				if (sched_count >= MAX_T) begin
					r.status = tdq_pkg::ST_FULL;
				end else begin
					last_id = last_id + 1'b1;
					if (last_id == '0)
						last_id = 1;
					sum = longint'(now) + longint'(delay) + longint'(off);
					if (sum < 0)
						sum = 0;
					else if (sum > longint'(TIME_TOP))
						sum = longint'(TIME_TOP);
					sched_deadline[sched_count] = sum[TIME_W-1:0];
					sched_ident[sched_count] = last_id;
					sched_count++;
					r.status = tdq_pkg::ST_OK;
					r.id = last_id;
				end
			end
			tdq_pkg::MODE_DELETE: begin
				for (int i = 0; i < sched_count; i++)
					if (hit < 0 && sched_ident[i] == tid)
						hit = i;
				if (hit >= 0) begin
					drop_entry(hit);
					r.status = tdq_pkg::ST_OK;
				end
			end
			tdq_pkg::MODE_POLL: begin
				for (int i = 0; i < sched_count; i++)
					if (sched_deadline[i] <= now &&
						(hit < 0 || sched_deadline[i] < sched_deadline[hit]))
						hit = i;
				if (hit >= 0) begin
					r.id = sched_ident[hit];
					drop_entry(hit);
					r.status = tdq_pkg::ST_OK;
				end
			end
			default: ;
		endcase
		r.count = sched_count[CNT_W-1:0];
		return r;
	endfunction

	task automatic send_word(input logic [tdq_pkg::MODE_W-1:0] op,
		input logic [TIME_W-1:0] now,
		input logic [TIME_W-1:0] delay, input logic signed [31:0] off,
		input logic [ID_W-1:0] tid, input int idle_pct);
		int gap;
		gap = 0;
		while (gap < 40 && $urandom_range(0, 99) < idle_pct)
			gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start     <= 1'b1;
		mode      <= op;
		now_ms    <= now;
		delay_ms  <= delay;
		offset_ms <= off;
		timer_id  <= tid;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		expected_replies.insert(expected_replies.size(),
			apply_timer_op(op, now, delay, off, tid));
	endtask

	// hold off until every reply has come back
	task automatic settle_idle();
		start <= 1'b0;
		do
			@(posedge clk);
		while (expected_replies.size() != 0);
	endtask

	task automatic test_empty_table();
		send_word(tdq_pkg::MODE_POLL, '0, '0, '0, '0, 0);
		send_word(tdq_pkg::MODE_POLL, TIME_TOP, TIME_TOP, OFF_MAX, '1, 0);
		send_word(tdq_pkg::MODE_DELETE, '0, '0, '0, '0, 0);
		send_word(tdq_pkg::MODE_DELETE, TIME_TOP, '0, OFF_MIN, '1, 0);
	endtask

	task automatic test_saturation();
		send_word(tdq_pkg::MODE_SET, TIME_TOP, TIME_TOP, OFF_MAX, '0, 0);
		send_word(tdq_pkg::MODE_SET, TIME_TOP, TIME_TOP, OFF_MIN, '0, 0);
		send_word(tdq_pkg::MODE_SET, '0, '0, OFF_MIN, '0, 0);
		send_word(tdq_pkg::MODE_SET, '0, '0, -32'sd1, '0, 0);
		send_word(tdq_pkg::MODE_SET, 48'd5, '0, -32'sd5, '0, 0);
		send_word(tdq_pkg::MODE_SET, TIME_TOP - 48'd10, 48'd5, 32'sd5, '0, 0);
	endtask

	task automatic test_poll_ties();
		send_word(tdq_pkg::MODE_POLL, '0, '0, '0, '0, 0);
		send_word(tdq_pkg::MODE_POLL, '0, '0, '0, '0, 0);
		send_word(tdq_pkg::MODE_POLL, TIME_TOP - 48'd1, '0, '0, '0, 0);
		send_word(tdq_pkg::MODE_POLL, TIME_TOP, '0, '0, '0, 0);
	endtask

	task automatic test_delete();
		send_word(tdq_pkg::MODE_DELETE, '0, '0, '0, 32'd6, 0);
		send_word(tdq_pkg::MODE_DELETE, '0, '0, '0, 32'd2, 0);
		send_word(tdq_pkg::MODE_DELETE, '0, '0, '0, 32'd2, 0);
		send_word(tdq_pkg::MODE_DELETE, '0, '0, '0, '0, 0);
	endtask

	task automatic test_unused_mode();
		send_word(tdq_pkg::MODE_SET, 48'd100, '0, '0, '0, 0);
		send_word(MODE_SPARE, TIME_TOP, TIME_TOP, OFF_MAX, 32'd7, 0);
		send_word(tdq_pkg::MODE_POLL, TIME_TOP, '0, '0, '0, 0);
	endtask

	task automatic test_random_traffic(input int items, input int idle_pct);
		logic [tdq_pkg::MODE_W-1:0] op;
		logic [TIME_W-1:0]  now, delay;
		logic signed [31:0] off;
		logic [ID_W-1:0]    tid;
		int roll;
		for (int k = 0; k < items; k++) begin
			clock_ms = clock_ms + TIME_W'($urandom_range(0, 24));
			now   = clock_ms;
			delay = TIME_W'($urandom_range(0, 300));
			off   = int'($urandom_range(0, 100)) - 50;
			tid   = (sched_count > 0) ? sched_ident[$urandom_range(0, sched_count - 1)]
				: ID_W'($urandom);
			roll  = $urandom_range(0, 99);
			if (roll < 12) begin
				roll  = $urandom_range(0, 3);
				op    = roll[tdq_pkg::MODE_W-1:0];
				now   = rand_time();
				delay = rand_time();
				off   = $urandom;
				tid   = $urandom;
			end else begin
				roll = $urandom_range(0, 99);
				if (filling)
					op = (roll < 70) ? tdq_pkg::MODE_SET :
						(roll < 85) ? tdq_pkg::MODE_POLL : tdq_pkg::MODE_DELETE;
				else
					op = (roll < 15) ? tdq_pkg::MODE_SET :
						(roll < 65) ? tdq_pkg::MODE_POLL : tdq_pkg::MODE_DELETE;
				if (op == tdq_pkg::MODE_DELETE && $urandom_range(0, 9) == 0)
					tid = $urandom;
			end
			send_word(op, now, delay, off, tid, idle_pct);
			if (sched_count == MAX_T && $urandom_range(0, 3) == 0)
				filling = 1'b0;
			if (sched_count == 0)
				filling = 1'b1;
			if ($urandom_range(0, 39) == 0)
				settle_idle();
		end
	endtask

	always @(posedge clk) begin : check_reply
		reply_t want;
		if (arst_n && done) begin
			if (expected_replies.size() == 0) begin
				$error("reply with no command pending: status %0d id %0d count %0d",
					status, result_id, live_count);
				mismatches++;
			end else begin
				want = expected_replies[0];
				expected_replies.delete(0);
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					mismatches++;
				end
				if (result_id !== want.id) begin
					$error("result_id: expected %0d, got %0d", want.id, result_id);
					mismatches++;
				end
				if (live_count !== want.count) begin
					$error("live_count: expected %0d, got %0d", want.count, live_count);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("timer_deadline_queue_test: FAIL");
				$finish;
			end
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_saturation();
		test_poll_ties();
		test_delete();
		test_unused_mode();
		settle_idle();
		test_random_traffic(310, 0);
		test_random_traffic(310, 81);
		test_random_traffic(310, 0);
		test_random_traffic(310, 12);
		settle_idle();
		repeat (2 * MAX_T + 16) @(posedge clk);
		if (mismatches == 0)
			$display("timer_deadline_queue_test: PASS");
		else
			$display("timer_deadline_queue_test: FAIL");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+sv
sv/tdq_pkg.sv
sv/tdq_ctrl.sv
sv/tdq_datapath.sv
sv/timer_deadline_queue.sv
sv/tdq_checker.sv
sim/timer_deadline_queue_test.sv
